// File: sv/elastic_collision_response_2d_defines.svh
`ifndef ELASTIC_COLLISION_RESPONSE_2D_DEFINES_SVH
`define ELASTIC_COLLISION_RESPONSE_2D_DEFINES_SVH

// Check a property on the rising clock edge, skipped while reset is held.
`define ECR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define ECR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ecr_pkg.sv
`timescale 1ns / 1ps

package ecr_pkg;

  localparam int VW       = 32;            // velocity, position and mass width
  localparam int DIFW     = VW + 1;        // exact difference width
  localparam int PRW      = 2 * DIFW;      // product of two differences
  localparam int NUMW     = PRW + DIFW;    // dot product times one axis
  localparam int Q1W      = DIFW;          // projection quotient bits
  localparam int MTW      = VW + 1;        // total mass width
  localparam int Q2W      = MTW + 1;       // impulse quotient bits
  localparam int SUMW     = Q2W + 2;       // velocity plus signed impulse
  localparam int NLANE    = 4;             // impulse lanes
  localparam int PIPE_STG = 4 + (Q1W + 1) + 1 + (Q2W + 1);

  typedef struct packed {
    logic signed [VW-1:0] v1x;
    logic signed [VW-1:0] v1y;
    logic signed [VW-1:0] v2x;
    logic signed [VW-1:0] v2y;
    logic [VW-1:0]        m1;
    logic [VW-1:0]        m2;
    logic [MTW-1:0]       mtot;
    logic                 degen;
    logic                 nx_neg;
    logic                 ny_neg;
  } com_t;

  typedef struct packed {
    com_t            c;
    logic [DIFW-1:0] nxm;
    logic [DIFW-1:0] nym;
    logic [DIFW-1:0] dvxm;
    logic [DIFW-1:0] dvym;
    logic            ax_neg;
    logic            ay_neg;
  } s0_t;

  typedef struct packed {
    com_t            c;
    logic [DIFW-1:0] nxm;
    logic [DIFW-1:0] nym;
    logic [PRW-1:0]  ax;
    logic [PRW-1:0]  ay;
    logic [PRW-1:0]  nx2;
    logic [PRW-1:0]  ny2;
    logic            ax_neg;
    logic            ay_neg;
  } s1_t;

  typedef struct packed {
    com_t            c;
    logic [DIFW-1:0] nxm;
    logic [DIFW-1:0] nym;
    logic [PRW-1:0]  dotm;
    logic [PRW-1:0]  d2;
    logic            dot_neg;
  } s2_t;

  typedef struct packed {
    com_t           c;
    logic [PRW-1:0] d2;
    logic           dot_neg;
    logic [PRW-1:0] pxl;
    logic [PRW-1:0] pxh;
    logic [PRW-1:0] pyl;
    logic [PRW-1:0] pyh;
  } s3_t;

  typedef struct packed {
    logic [PRW-1:0] rem;
    logic [Q1W-1:0] q;
  } dq1_t;

  typedef struct packed {
    com_t           c;
    logic [PRW-1:0] d2;
    logic           dot_neg;
    dq1_t           x;
    dq1_t           y;
  } d1s_t;

  typedef struct packed {
    com_t                       c;
    logic                       sx_neg;
    logic                       sy_neg;
    logic [NLANE-1:0][PRW-1:0]  p;
  } im_t;

  typedef struct packed {
    logic [MTW-1:0] rem;
    logic [Q2W-1:0] q;
  } dq2_t;

  typedef struct packed {
    com_t                  c;
    logic                  sx_neg;
    logic                  sy_neg;
    dq2_t [NLANE-1:0]      l;
  } d2s_t;

  function automatic logic [DIFW-1:0] mag(input logic signed [DIFW-1:0] a);
    mag = a[DIFW-1] ? DIFW'(-a) : DIFW'(a);
  endfunction

  // One restoring step of the projection divide.
  function automatic dq1_t div1_step(input dq1_t a, input logic [PRW-1:0] d);
    logic [PRW:0] t;
    logic         ge;
    dq1_t         r;
    t  = {a.rem, a.q[Q1W-1]};
    ge = (t >= {1'b0, d});
    r.rem = ge ? PRW'(t - {1'b0, d}) : t[PRW-1:0];
    r.q   = {a.q[Q1W-2:0], ge};
    return r;
  endfunction

  // One restoring step of the impulse divide by total mass.
  function automatic dq2_t div2_step(input dq2_t a, input logic [MTW-1:0] d);
    logic [MTW:0] t;
    logic         ge;
    dq2_t         r;
    t  = {a.rem, a.q[Q2W-1]};
    ge = (t >= {1'b0, d});
    r.rem = ge ? MTW'(t - {1'b0, d}) : t[MTW-1:0];
    r.q   = {a.q[Q2W-2:0], ge};
    return r;
  endfunction

  function automatic logic [VW-1:0] sat(input logic signed [SUMW-1:0] a);
    logic same;
    same = (a[SUMW-1:VW-1] == {(SUMW-VW+1){1'b0}}) ||
           (a[SUMW-1:VW-1] == {(SUMW-VW+1){1'b1}});
    if (same) begin
      sat = a[VW-1:0];
    end else if (a[SUMW-1]) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end
  endfunction

endpackage

// File: sv/elastic_collision_response_2d.sv
// Throughput: one transaction per cycle while the output is not stalled; the two
// unrolled restoring dividers (33 and 34 stages, one quotient bit per stage) set the depth.
// A stalled output holds the whole pipeline in place; nothing is dropped.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps

module elastic_collision_response_2d import ecr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // first_vel_x, first_vel_y, first_pos_x, first_pos_y, first_mass,
  // second_vel_x, second_vel_y, second_pos_x, second_pos_y, second_mass
  input  logic [10*VW-1:0]     in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
  output logic [4*VW-1:0]      out_tdata,
  // degenerate
  output logic                 out_tuser
);

  // Whole pipeline advances together: free when the output slot is empty
  // or being taken this cycle.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic [PIPE_STG-1:0] vld_r;
  logic                out_valid_r;
  logic [4*VW-1:0]     out_tdata_r;
  logic                out_tuser_r;

  s0_t  s0_r, s0_nxt;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  d1s_t d1_r   [0:Q1W];
  d1s_t d1_nxt [0:Q1W];
  im_t  im_r, im_nxt;
  d2s_t d2_r   [0:Q2W];
  d2s_t d2_nxt [0:Q2W];
  logic [4*VW-1:0] out_tdata_nxt;

  // Stage 0: unpack, take differences, flag coinciding points / zero mass.
  always_comb begin
    logic signed [VW-1:0]   p1x, p1y, p2x, p2y;
    logic signed [DIFW-1:0] nx, ny, dvx, dvy;
    p1x = in_tdata[2*VW +: VW];
    p1y = in_tdata[3*VW +: VW];
    p2x = in_tdata[7*VW +: VW];
    p2y = in_tdata[8*VW +: VW];
    s0_nxt.c.v1x = in_tdata[0*VW +: VW];
    s0_nxt.c.v1y = in_tdata[1*VW +: VW];
    s0_nxt.c.m1  = in_tdata[4*VW +: VW];
    s0_nxt.c.v2x = in_tdata[5*VW +: VW];
    s0_nxt.c.v2y = in_tdata[6*VW +: VW];
    s0_nxt.c.m2  = in_tdata[9*VW +: VW];
    nx  = DIFW'(p1x) - DIFW'(p2x);
    ny  = DIFW'(p1y) - DIFW'(p2y);
    dvx = DIFW'(s0_nxt.c.v1x) - DIFW'(s0_nxt.c.v2x);
    dvy = DIFW'(s0_nxt.c.v1y) - DIFW'(s0_nxt.c.v2y);
    s0_nxt.c.mtot   = {1'b0, s0_nxt.c.m1} + {1'b0, s0_nxt.c.m2};
    s0_nxt.c.degen  = ((nx == '0) && (ny == '0)) || (s0_nxt.c.mtot == '0);
    s0_nxt.c.nx_neg = nx[DIFW-1];
    s0_nxt.c.ny_neg = ny[DIFW-1];
    s0_nxt.nxm    = mag(nx);
    s0_nxt.nym    = mag(ny);
    s0_nxt.dvxm   = mag(dvx);
    s0_nxt.dvym   = mag(dvy);
    s0_nxt.ax_neg = dvx[DIFW-1] ^ nx[DIFW-1];
    s0_nxt.ay_neg = dvy[DIFW-1] ^ ny[DIFW-1];
  end

  // Stage 1: dot product terms and squared distance terms.
  always_comb begin
    s1_nxt.c      = s0_r.c;
    s1_nxt.nxm    = s0_r.nxm;
    s1_nxt.nym    = s0_r.nym;
    s1_nxt.ax     = PRW'(s0_r.dvxm * s0_r.nxm);
    s1_nxt.ay     = PRW'(s0_r.dvym * s0_r.nym);
    s1_nxt.nx2    = PRW'(s0_r.nxm * s0_r.nxm);
    s1_nxt.ny2    = PRW'(s0_r.nym * s0_r.nym);
    s1_nxt.ax_neg = s0_r.ax_neg;
    s1_nxt.ay_neg = s0_r.ay_neg;
  end

  // Stage 2: sign-magnitude sum of the dot product, squared distance.
  always_comb begin
    s2_nxt.c   = s1_r.c;
    s2_nxt.nxm = s1_r.nxm;
    s2_nxt.nym = s1_r.nym;
    s2_nxt.d2  = s1_r.nx2 + s1_r.ny2;
    if (s1_r.ax_neg == s1_r.ay_neg) begin
      s2_nxt.dotm    = s1_r.ax + s1_r.ay;
      s2_nxt.dot_neg = s1_r.ax_neg;
    end else if (s1_r.ax >= s1_r.ay) begin
      s2_nxt.dotm    = s1_r.ax - s1_r.ay;
      s2_nxt.dot_neg = s1_r.ax_neg;
    end else begin
      s2_nxt.dotm    = s1_r.ay - s1_r.ax;
      s2_nxt.dot_neg = s1_r.ay_neg;
    end
  end

  // Stage 3: dot times each axis, split into two partial products.
  always_comb begin
    s3_nxt.c       = s2_r.c;
    s3_nxt.d2      = s2_r.d2;
    s3_nxt.dot_neg = s2_r.dot_neg;
    s3_nxt.pxl     = PRW'(s2_r.dotm[Q1W-1:0] * s2_r.nxm);
    s3_nxt.pxh     = PRW'(s2_r.dotm[PRW-1:Q1W] * s2_r.nxm);
    s3_nxt.pyl     = PRW'(s2_r.dotm[Q1W-1:0] * s2_r.nym);
    s3_nxt.pyh     = PRW'(s2_r.dotm[PRW-1:Q1W] * s2_r.nym);
  end

  // Projection divider: join partial products, then one quotient bit per stage.
  always_comb begin
    logic [NUMW-1:0] numx, numy;
    numx = NUMW'(s3_r.pxl) + {s3_r.pxh, {Q1W{1'b0}}};
    numy = NUMW'(s3_r.pyl) + {s3_r.pyh, {Q1W{1'b0}}};
    d1_nxt[0].c       = s3_r.c;
    d1_nxt[0].d2      = s3_r.d2;
    d1_nxt[0].dot_neg = s3_r.dot_neg;
    d1_nxt[0].x.rem   = numx[NUMW-1:Q1W];
    d1_nxt[0].x.q     = numx[Q1W-1:0];
    d1_nxt[0].y.rem   = numy[NUMW-1:Q1W];
    d1_nxt[0].y.q     = numy[Q1W-1:0];
    for (int k = 0; k < Q1W; k++) begin
      d1_nxt[k+1]   = d1_r[k];
      d1_nxt[k+1].x = div1_step(d1_r[k].x, d1_r[k].d2);
      d1_nxt[k+1].y = div1_step(d1_r[k].y, d1_r[k].d2);
    end
  end

  // Impulse numerators: projection times twice each mass.
  always_comb begin
    im_nxt.c      = d1_r[Q1W].c;
    im_nxt.sx_neg = d1_r[Q1W].dot_neg ^ d1_r[Q1W].c.nx_neg;
    im_nxt.sy_neg = d1_r[Q1W].dot_neg ^ d1_r[Q1W].c.ny_neg;
    im_nxt.p[0]   = PRW'(d1_r[Q1W].x.q * {d1_r[Q1W].c.m2, 1'b0});
    im_nxt.p[1]   = PRW'(d1_r[Q1W].y.q * {d1_r[Q1W].c.m2, 1'b0});
    im_nxt.p[2]   = PRW'(d1_r[Q1W].x.q * {d1_r[Q1W].c.m1, 1'b0});
    im_nxt.p[3]   = PRW'(d1_r[Q1W].y.q * {d1_r[Q1W].c.m1, 1'b0});
  end

  // Impulse divider by total mass, four lanes side by side.
  always_comb begin
    d2_nxt[0].c      = im_r.c;
    d2_nxt[0].sx_neg = im_r.sx_neg;
    d2_nxt[0].sy_neg = im_r.sy_neg;
    for (int i = 0; i < NLANE; i++) begin
      d2_nxt[0].l[i].rem = {1'b0, im_r.p[i][PRW-1:Q2W]};
      d2_nxt[0].l[i].q   = im_r.p[i][Q2W-1:0];
    end
    for (int k = 0; k < Q2W; k++) begin
      d2_nxt[k+1] = d2_r[k];
      for (int i = 0; i < NLANE; i++) begin
        d2_nxt[k+1].l[i] = div2_step(d2_r[k].l[i], d2_r[k].c.mtot);
      end
    end
  end

  // Apply signed impulses and saturate; degenerate pairs pass through.
  always_comb begin
    logic signed [SUMW-1:0] imp [NLANE];
    logic                   neg;
    for (int i = 0; i < NLANE; i++) begin
      neg    = (i % 2 == 0) ? d2_r[Q2W].sx_neg : d2_r[Q2W].sy_neg;
      imp[i] = neg ? -SUMW'(d2_r[Q2W].l[i].q) : SUMW'(d2_r[Q2W].l[i].q);
    end
    if (d2_r[Q2W].c.degen) begin
      out_tdata_nxt = {d2_r[Q2W].c.v2y, d2_r[Q2W].c.v2x,
                       d2_r[Q2W].c.v1y, d2_r[Q2W].c.v1x};
    end else begin
      out_tdata_nxt[0*VW +: VW] = sat(SUMW'(d2_r[Q2W].c.v1x) - imp[0]);
      out_tdata_nxt[1*VW +: VW] = sat(SUMW'(d2_r[Q2W].c.v1y) - imp[1]);
      out_tdata_nxt[2*VW +: VW] = sat(SUMW'(d2_r[Q2W].c.v2x) + imp[2]);
      out_tdata_nxt[3*VW +: VW] = sat(SUMW'(d2_r[Q2W].c.v2y) + imp[3]);
    end
  end

  // Valid bits and output flag: cleared on reset, advance with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_STG-2:0], in_tvalid};
      out_valid_r <= vld_r[PIPE_STG-1];
    end
  end

  // Payload: hold on stall, advance otherwise.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      for (int k = 0; k <= Q1W; k++) begin
        d1_r[k] <= d1_nxt[k];
      end
      im_r <= im_nxt;
      for (int k = 0; k <= Q2W; k++) begin
        d2_r[k] <= d2_nxt[k];
      end
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= d2_r[Q2W].c.degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: sv/ecr_chk.sv
`timescale 1ns / 1ps
`include "elastic_collision_response_2d_defines.svh"

module ecr_chk import ecr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [4*VW-1:0]   out_tdata,
  input logic              out_tuser
);

  `ECR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "output changed while stalled")
  `ECR_ASSERT(a_ready_empty, !out_tvalid |-> in_tready, "input stalled with empty output")
  `ECR_ASSERT(a_ready_stall, out_tvalid && !out_tready |-> !in_tready, "input taken during output stall")
  `ECR_ASSERT_RST(a_reset_clear, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind elastic_collision_response_2d ecr_chk u_ecr_chk (.*);

// File: dv/elastic_collision_response_2d_test.sv
`timescale 1ns / 1ps

module elastic_collision_response_2d_test;
  import ecr_pkg::*;

  // One body pair and the velocities after the collision.
  typedef struct {
    logic signed [31:0] v1x, v1y, p1x, p1y;
    logic [31:0]        m1;
    logic signed [31:0] v2x, v2y, p2x, p2y;
    logic [31:0]        m2;
  } pair_t;

  typedef struct {
    logic [31:0] v1x, v1y, v2x, v2y;
    logic        degen;
  } bounce_t;

  // Directed row: pair plus a typed-in answer where it is obvious.
  typedef struct {
    pair_t   p;
    bit      known;
    bounce_t r;
  } row_t;

  localparam int    LATENCY  = 74;
  localparam int    N_RANDOM = 1100;
  localparam logic [31:0] MAXP = 32'h7fffffff;
  localparam logic [31:0] MAXN = 32'h80000000;
  localparam logic [31:0] ONE  = 32'h00010000;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [319:0]  in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [127:0]  out_tdata;
  logic          out_tuser;

  bounce_t bounce_q[$];
  int      mismatches;
  int      n_sent;
  int      n_checked;
  int      n_degen;
  int      n_sat;
  int      send_idle_pct;
  int      recv_stall_pct;
  bit      recv_hold;

  elastic_collision_response_2d uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate an exact sum to the signed 32-bit range.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return MAXP;
    if (v < -128'sd2147483648) return MAXN;
    return v[31:0];
  endfunction

  // Impulse on one axis: s * 2m / M, the divide truncated toward zero.
  function automatic logic signed [127:0] kick(input logic signed [127:0] s,
                                               input logic [127:0] m,
                                               input logic [127:0] mtot);
    logic [127:0] mag;
    mag = (s < 0) ? -s : s;
    mag = (mag * 2 * m) / mtot;
    return (s < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Compute both post-collision velocities with exact wide arithmetic.
  function automatic bounce_t collide(input pair_t p);
    logic signed [127:0] nx, ny, dvx, dvy, dot, d2, sx, sy, t;
    logic [127:0]        mtot, um;
    bounce_t             r;
    nx   = 128'(p.p1x) - 128'(p.p2x);
    ny   = 128'(p.p1y) - 128'(p.p2y);
    dvx  = 128'(p.v1x) - 128'(p.v2x);
    dvy  = 128'(p.v1y) - 128'(p.v2y);
    mtot = {96'b0, p.m1} + {96'b0, p.m2};
    if ((nx == 0 && ny == 0) || mtot == 0) begin
      r.v1x = p.v1x; r.v1y = p.v1y; r.v2x = p.v2x; r.v2y = p.v2y;
      r.degen = 1'b1;
      return r;
    end
    dot = dvx * nx + dvy * ny;
    d2  = nx * nx + ny * ny;
    // Truncating signed divide: magnitude divide, then reapply the sign.
    t  = dot * nx;
    um = ((t < 0) ? -t : t) / d2;
    sx = (t < 0) ? -$signed(um) : $signed(um);
    t  = dot * ny;
    um = ((t < 0) ? -t : t) / d2;
    sy = (t < 0) ? -$signed(um) : $signed(um);
    r.v1x = clamp32(128'(p.v1x) - kick(sx, {96'b0, p.m2}, mtot));
    r.v1y = clamp32(128'(p.v1y) - kick(sy, {96'b0, p.m2}, mtot));
    r.v2x = clamp32(128'(p.v2x) + kick(sx, {96'b0, p.m1}, mtot));
    r.v2y = clamp32(128'(p.v2y) + kick(sy, {96'b0, p.m1}, mtot));
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] rnd_field(input int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 8) * 32'h00008000 - 32'h00020000;
      2: return 32'($signed($urandom_range(0, 400)) - 200) <<< 12;
      3: return $urandom_range(0, 1) ? MAXP - $urandom_range(0, 3)
                                     : MAXN + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 20000)) - 10000) <<< 8;
    endcase
  endfunction

  // Mostly moderate values so results stay in range; some wide ones to saturate.
  function automatic pair_t rnd_pair();
    pair_t p;
    int    k;
    k = $urandom_range(0, 9);
    if (k < 2) k = 0; else if (k < 3) k = 3; else k = 4;
    p.v1x = rnd_field(k); p.v1y = rnd_field(k);
    p.v2x = rnd_field(k); p.v2y = rnd_field(k);
    p.p1x = rnd_field(k == 0 ? 0 : 2); p.p1y = rnd_field(k == 0 ? 0 : 2);
    p.p2x = rnd_field(k == 0 ? 0 : 2); p.p2y = rnd_field(k == 0 ? 0 : 2);
    p.m1  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h00400000);
    p.m2  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h00400000);
    case ($urandom_range(0, 19))
      0: begin p.p2x = p.p1x; p.p2y = p.p1y; end  // coinciding centers
      1: begin p.m1 = '0; p.m2 = '0; end          // no mass at all
      2: p.m1 = '0;                               // one massless body
      3: p.p2y = p.p1y;                           // head-on along x
      default: ;
    endcase
    return p;
  endfunction

  // Push one transaction; the predicted answer is queued on acceptance.
  task automatic send(input pair_t p);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {p.m2, p.p2y, p.p2x, p.v2y, p.v2x, p.m1, p.p1y, p.p1x, p.v1y, p.v1x};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bounce_q = {bounce_q, collide(p)};
    n_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (bounce_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Receiver: random stalls, or a long hold while recv_hold is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !recv_hold && ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    bounce_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (bounce_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", out_tdata, out_tuser);
      end else begin
        e = bounce_q.pop_front();
        n_checked++;
        if (e.degen) n_degen++;
        if (out_tdata != {e.v2y, e.v2x, e.v1y, e.v1x} || out_tuser != e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp %h %h %h %h d=%b  got %h %h %h %h d=%b",
                     n_checked, e.v1x, e.v1y, e.v2x, e.v2y, e.degen,
                     out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                     out_tdata[127:96], out_tuser);
        end else if (out_tdata[31:0] == MAXP || out_tdata[31:0] == MAXN) begin
          n_sat++;
        end
      end
    end
  end

  row_t rows[$];

  function automatic row_t mk(input logic [31:0] v1x, v1y, p1x, p1y, m1,
                              input logic [31:0] v2x, v2y, p2x, p2y, m2,
                              input bit known, input bit dg);
    row_t r;
    r.p = '{v1x, v1y, p1x, p1y, m1, v2x, v2y, p2x, p2y, m2};
    r.known = known;
    r.r = '{v1x, v1y, v2x, v2y, dg};
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input row_t r);
    rows = {rows, r};
  endfunction

  initial begin
    int   i;
    int   hold;
    row_t r;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    mismatches = 0; n_sent = 0; n_checked = 0; n_degen = 0; n_sat = 0;
    send_idle_pct = 0; recv_stall_pct = 0; recv_hold = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: degenerate cases pass velocities through untouched.
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    add_row(mk(MAXP, MAXN, 5, 7, ONE, MAXN, MAXP, 5, 7, ONE, 1, 1));
    add_row(mk(ONE, 0, 0, 0, 0, 0, ONE, ONE, 0, 0, 1, 1));
    add_row(mk(32'hffffffff, 1, MAXP, MAXN, 32'hffffffff,
               1, 32'hffffffff, MAXP, MAXN, 32'hffffffff, 1, 1));
    // Equal masses head-on along x: velocities swap exactly.
    add_row(mk(ONE, 0, 0, 0, ONE, -ONE, 0, ONE, 0, ONE, 1, 0));
    r = rows[$]; r.r = '{-ONE, 0, ONE, 0, 1'b0}; rows[$] = r;
    // Massless first body reflects off the second as off a wall.
    add_row(mk(ONE, 0, 0, 0, 0, 0, 0, ONE, 0, ONE, 1, 0));
    r = rows[$]; r.r = '{-ONE, 0, 0, 0, 1'b0}; rows[$] = r;
    // Extremes and overflow, checked against the predictor.
    add_row(mk(MAXP, MAXP, MAXP, MAXP, 32'hffffffff,
               MAXN, MAXN, MAXN, MAXN, 32'hffffffff, 0, 0));
    add_row(mk(MAXN, MAXP, MAXN, 0, 1, MAXP, MAXN, MAXP, 0, 32'hffffffff, 0, 0));
    add_row(mk(MAXP, 0, 1, 0, 32'hffffffff, MAXN, 0, 0, 0, 1, 0, 0));
    add_row(mk(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321, 32'haaaaaaaa,
               32'h55555555, 32'hdeadbeef, 32'h76543210, 32'hfedcba98, 32'h55555555,
               0, 0));
    add_row(mk(ONE, ONE, 0, 0, ONE, 0, 0, ONE, ONE, 3 * ONE, 0, 0));
    add_row(mk(0, ONE, 0, 2 * ONE, 0, 0, -ONE, 0, 0, ONE, 0, 0));
    add_row(mk(3, -5, 1, 1, 1, -7, 2, 0, 0, 0, 0, 0));

    foreach (rows[i]) begin
      send(rows[i].p);
      if (rows[i].known) bounce_q[$] = rows[i].r;
    end
    drain();

    // Random phases: no idling, sender idle, receiver stall, both.
    for (i = 0; i < N_RANDOM; i++) begin
      case (i * 4 / N_RANDOM)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (i == N_RANDOM / 8) begin
        // Hold off the receiver long enough for the pipeline to fill and
        // back-pressure the input; the sender keeps offering meanwhile.
        recv_hold = 1'b1;
        fork
          begin
            for (hold = 0; hold < 3 * LATENCY; hold++) @(posedge clk);
            recv_hold = 1'b0;
          end
        join_none
      end
      if (i == N_RANDOM / 2) drain();  // pause until every result is back
      send(rnd_pair());
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("sent %0d pairs, checked %0d results (%0d degenerate, %0d saturated x)",
             n_sent, n_checked, n_degen, n_sat);
    if (mismatches == 0 && bounce_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, bounce_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", bounce_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
